// File: src/evpq_pkg.sv
// Shared types and constants of the event priority queue.
package evpq_pkg;

  localparam int TICK_W   = 64;
  localparam int SEQ_W    = 64;
  localparam int PHASE_W  = 3;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_PHASE = 3'd4;

  localparam logic [PHASE_W-1:0] PHASE_INVALID = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DISPATCH,
    OP_SCAN_START,
    OP_SCAN_RD,
    OP_FETCH_LAST,
    OP_EMIT_BEST
  } dp_op_t;

  typedef struct packed {
    logic   in_ready;
    logic   load_req;
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_query;
    logic empty;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/evpq_ifs.sv
// Handshake channel interfaces for command and result beats.
interface evpq_in_if #(
  parameter int KIND_BITS   = 8,
  parameter int ENTITY_BITS = 32
);
  logic                           valid;
  logic                           ready;
  logic [evpq_pkg::CMD_W-1:0]     cmd;
  logic [evpq_pkg::TICK_W-1:0]    event_tick;
  logic [evpq_pkg::PHASE_W-1:0]   event_phase;
  logic [KIND_BITS-1:0]           event_kind;
  logic [ENTITY_BITS-1:0]         entity_tag;
  logic                           cause_present;
  logic [evpq_pkg::SEQ_W-1:0]     cause_number;

  modport source (output valid, cmd, event_tick, event_phase, event_kind, entity_tag,
                  cause_present, cause_number, input ready);
  modport sink   (input valid, cmd, event_tick, event_phase, event_kind, entity_tag,
                  cause_present, cause_number, output ready);
endinterface

interface evpq_out_if #(
  parameter int KIND_BITS   = 8,
  parameter int ENTITY_BITS = 32,
  parameter int OCC_W       = 7
);
  logic                            valid;
  logic                            ready;
  logic [evpq_pkg::STATUS_W-1:0]   status;
  logic [evpq_pkg::SEQ_W-1:0]      out_sequence;
  logic [evpq_pkg::TICK_W-1:0]     out_tick;
  logic [evpq_pkg::PHASE_W-1:0]    out_phase;
  logic [KIND_BITS-1:0]            out_kind;
  logic [ENTITY_BITS-1:0]          out_entity_tag;
  logic                            out_cause_present;
  logic [evpq_pkg::SEQ_W-1:0]      out_cause_number;
  logic [OCC_W-1:0]                occupancy;

  modport source (output valid, status, out_sequence, out_tick, out_phase, out_kind,
                  out_entity_tag, out_cause_present, out_cause_number, occupancy,
                  input ready);
  modport sink   (input valid, status, out_sequence, out_tick, out_phase, out_kind,
                  out_entity_tag, out_cause_present, out_cause_number, occupancy,
                  output ready);
endinterface

// File: src/evpq_ctrl.sv
// Controller state machine: dispatch, scan for the earliest event, emit.
module evpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  evpq_pkg::dp_stat_t stat,
  output evpq_pkg::dp_ctrl_t ctrl
);
  import evpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_TAIL,
    S_FINISH
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (stat.in_valid) state_r <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (stat.is_query && !stat.empty) state_r <= S_SCAN;
          else if (stat.out_free)           state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (stat.scan_last) state_r <= S_TAIL;
        end
        S_TAIL: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.in_ready = (state_r == S_IDLE);
    ctrl.load_req = (state_r == S_IDLE) && stat.in_valid;
    ctrl.op       = OP_NONE;
    unique case (state_r)
      S_IDLE:   ctrl.op = OP_NONE;
      S_DISPATCH: begin
        if (stat.is_query && !stat.empty) ctrl.op = OP_SCAN_START;
        else if (stat.out_free)           ctrl.op = OP_DISPATCH;
      end
      S_SCAN:   ctrl.op = OP_SCAN_RD;
      S_TAIL:   ctrl.op = OP_FETCH_LAST;
      S_FINISH: begin
        if (stat.out_free) ctrl.op = OP_EMIT_BEST;
      end
      default:  ctrl.op = OP_NONE;
    endcase
  end

endmodule

// File: src/evpq_dp.sv
// Datapath: slot memory, counters, earliest-event search and result register.
module evpq_dp #(
  parameter int QUEUE_DEPTH = 64,
  parameter int KIND_BITS   = 8,
  parameter int ENTITY_BITS = 32,
  parameter int IDX_W       = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  evpq_pkg::dp_ctrl_t ctrl,
  output evpq_pkg::dp_stat_t stat,
  evpq_in_if.sink            in_ch,
  evpq_out_if.source         out_ch
);
  import evpq_pkg::*;

  typedef struct packed {
    logic [TICK_W-1:0]      tick;
    logic [PHASE_W-1:0]     phase;
    logic [SEQ_W-1:0]       seq;
    logic [KIND_BITS-1:0]   kind;
    logic [ENTITY_BITS-1:0] entity;
    logic                   cause_flag;
    logic [SEQ_W-1:0]       cause;
  } rec_t;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [TICK_W-1:0]      tick;
    logic [PHASE_W-1:0]     phase;
    logic [KIND_BITS-1:0]   kind;
    logic [ENTITY_BITS-1:0] entity;
    logic                   cause_flag;
    logic [SEQ_W-1:0]       cause;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SEQ_W-1:0]       seq;
    logic [TICK_W-1:0]      tick;
    logic [PHASE_W-1:0]     phase;
    logic [KIND_BITS-1:0]   kind;
    logic [ENTITY_BITS-1:0] entity;
    logic                   cause_flag;
    logic [SEQ_W-1:0]       cause;
    logic [CNT_W-1:0]       occupancy;
  } res_t;

  rec_t             mem [QUEUE_DEPTH];
  rec_t             rd_data_r;
  req_t             req_r;
  res_t             res_r;
  res_t             res_nxt;
  rec_t             best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             best_valid_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             rd_pend_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [SEQ_W-1:0] seq_r;
  logic             spent_r;
  logic             out_valid_r;
  logic             out_free;
  logic             emit;
  logic             sched_ok;
  logic [CNT_W-1:0] last_cnt;
  logic             is_pop;
  logic             take_rd;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rec_t             mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  assign out_free = !out_valid_r || out_ch.ready;
  assign last_cnt = count_r - 1'b1;
  assign is_pop   = (req_r.cmd == CMD_POP);
  assign emit     = (ctrl.op == OP_DISPATCH) || (ctrl.op == OP_EMIT_BEST);

  assign stat.in_valid  = in_ch.valid;
  assign stat.is_query  = (req_r.cmd == CMD_PEEK) || (req_r.cmd == CMD_POP);
  assign stat.empty     = (count_r == '0);
  assign stat.scan_last = (CNT_W'(scan_idx_r) == last_cnt);
  assign stat.out_free  = out_free;

  assign in_ch.ready = ctrl.in_ready;

  // Keep the first candidate, then any that sorts ahead on {tick, phase, sequence}.
  assign take_rd = rd_pend_r &&
                   (!best_valid_r ||
                    ({rd_data_r.tick, rd_data_r.phase, rd_data_r.seq} <
                     {best_r.tick, best_r.phase, best_r.seq}));

  always_comb begin
    res_nxt           = '0;
    res_nxt.status    = ST_OK;
    res_nxt.occupancy = count_r;
    count_nxt         = count_r;
    sched_ok          = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = count_r[IDX_W-1:0];
    mem_wdata         = rd_data_r;
    if (ctrl.op == OP_DISPATCH) begin
      unique case (req_r.cmd)
        CMD_SCHEDULE: begin
          priority if (spent_r) begin
            res_nxt.status = ST_EXHAUSTED;
          end else if (req_r.phase == PHASE_INVALID) begin
            res_nxt.status = ST_BAD_PHASE;
          end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            res_nxt.status = ST_FULL;
          end else begin
            sched_ok             = 1'b1;
            count_nxt            = count_r + 1'b1;
            res_nxt.seq          = seq_r;
            res_nxt.occupancy    = count_nxt;
            mem_we               = 1'b1;
            mem_wdata.tick       = req_r.tick;
            mem_wdata.phase      = req_r.phase;
            mem_wdata.seq        = seq_r;
            mem_wdata.kind       = req_r.kind;
            mem_wdata.entity     = req_r.entity;
            mem_wdata.cause_flag = req_r.cause_flag;
            mem_wdata.cause      = req_r.cause_flag ? req_r.cause : '0;
          end
        end
        CMD_PEEK, CMD_POP: res_nxt.status = ST_EMPTY;
        default:           res_nxt.status = ST_OK;
      endcase
    end else if (ctrl.op == OP_EMIT_BEST) begin
      res_nxt.seq        = best_r.seq;
      res_nxt.tick       = best_r.tick;
      res_nxt.phase      = best_r.phase;
      res_nxt.kind       = best_r.kind;
      res_nxt.entity     = best_r.entity;
      res_nxt.cause_flag = best_r.cause_flag;
      res_nxt.cause      = best_r.cause;
      if (is_pop) begin
        // Move the last slot into the hole left by the popped one.
        count_nxt         = last_cnt;
        res_nxt.occupancy = last_cnt;
        mem_we            = 1'b1;
        mem_waddr         = best_idx_r;
        mem_wdata         = rd_data_r;
      end
    end
    mem_re    = (ctrl.op == OP_SCAN_RD) || (ctrl.op == OP_FETCH_LAST);
    mem_raddr = (ctrl.op == OP_FETCH_LAST) ? last_cnt[IDX_W-1:0] : scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      req_r.cmd        <= in_ch.cmd;
      req_r.tick       <= in_ch.event_tick;
      req_r.phase      <= in_ch.event_phase;
      req_r.kind       <= in_ch.event_kind;
      req_r.entity     <= in_ch.entity_tag;
      req_r.cause_flag <= in_ch.cause_present;
      req_r.cause      <= in_ch.cause_number;
    end
    if (emit) res_r <= res_nxt;
    if (ctrl.op == OP_SCAN_RD) cmp_idx_r <= scan_idx_r;
    if (take_rd) begin
      best_r     <= rd_data_r;
      best_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      seq_r        <= '0;
      spent_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      best_valid_r <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      count_r   <= count_nxt;
      rd_pend_r <= (ctrl.op == OP_SCAN_RD);
      if (sched_ok) begin
        if (seq_r == '1) spent_r <= 1'b1;
        else             seq_r   <= seq_r + 1'b1;
      end
      if (emit)                           out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (ctrl.op == OP_SCAN_START) begin
        scan_idx_r   <= '0;
        best_valid_r <= 1'b0;
      end else if (ctrl.op == OP_SCAN_RD) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (take_rd) best_valid_r <= 1'b1;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = res_r.status;
  assign out_ch.out_sequence      = res_r.seq;
  assign out_ch.out_tick          = res_r.tick;
  assign out_ch.out_phase         = res_r.phase;
  assign out_ch.out_kind          = res_r.kind;
  assign out_ch.out_entity_tag    = res_r.entity;
  assign out_ch.out_cause_present = res_r.cause_flag;
  assign out_ch.out_cause_number  = res_r.cause;
  assign out_ch.occupancy         = res_r.occupancy;

endmodule

// File: src/event_priority_queue_core.sv
// Top level of the pending-event priority queue.
// Pending-event queue for a discrete-event simulator. Each command beat on in_ch
// schedules an event, peeks at the earliest one or pops it, and gives exactly one
// result beat on out_ch. Events order by tick, then phase code (0 first), then by
// the 64-bit sequence number given at schedule time; the last sequence value is
// usable once, after which every schedule reports exhaustion. A schedule, a rejected
// command, a no-op or a peek/pop on an empty queue is answered from the dispatch step;
// a peek or pop on a non-empty queue first searches the N pending events, since the
// slot memory has one read port and the search for the earliest event reads one slot
// per cycle. A pop then fills its hole with the last slot. One command is in flight at
// a time; a finished result sits in the output register and the next command beat is
// taken while it waits.
module event_priority_queue_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int KIND_BITS   = 8,
  parameter int ENTITY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  evpq_in_if.sink    in_ch,
  evpq_out_if.source out_ch
);
  import evpq_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequence the search, dispatch and emit steps.
  evpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Hold slots, counters and the result register.
  evpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KIND_BITS   (KIND_BITS),
    .ENTITY_BITS (ENTITY_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Occupancy never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.occupancy <= QUEUE_DEPTH))
    else $error("occupancy above capacity");

  // An empty report only comes with an empty queue.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_EMPTY)) |-> (out_ch.occupancy == 0))
    else $error("empty status with pending events");

  // A full report only comes with a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_FULL)) |-> (out_ch.occupancy == QUEUE_DEPTH))
    else $error("full status below capacity");

  // A command beat is never taken while a search is running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_SCAN_RD) |-> !in_ch.ready)
    else $error("command accepted during search");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the pending-event priority queue.
`timescale 1ns / 1ps
module tb_top;
  import evpq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [63:0] SEQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] tick;
    logic [2:0]  phase;
    logic [7:0]  kind;
    logic [31:0] tag;
    logic        has_cause;
    logic [63:0] cause;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] seq_no;
    logic [63:0] tick;
    logic [2:0]  phase;
    logic [7:0]  kind;
    logic [31:0] tag;
    logic        has_cause;
    logic [63:0] cause;
    logic [6:0]  occ;
  } result_beat_t;

  // Directed row: command plus an optional typed-in result.
  typedef struct {
    cmd_beat_t    c;
    bit           fixed;
    result_beat_t r;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  evpq_in_if  #(.KIND_BITS(8), .ENTITY_BITS(32)) in_ch ();
  evpq_out_if #(.KIND_BITS(8), .ENTITY_BITS(32), .OCC_W(7)) out_ch ();

  event_priority_queue_core #(.QUEUE_DEPTH(DEPTH), .KIND_BITS(8), .ENTITY_BITS(32))
    DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  // Predictor state: a mirror of the pending events.
  cmd_beat_t    pend_ev [DEPTH];
  logic [63:0]  pend_seq [DEPTH];
  int           pend_cnt;
  logic [63:0]  next_seq;
  bit           seq_spent;
  result_beat_t expected_q [$];
  int           n_fail;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  // Compute the result of one command and advance the mirrored queue.
  function automatic result_beat_t predict_result(cmd_beat_t c);
    result_beat_t r;
    int b;
    r = '0;
    if (c.cmd == CMD_SCHEDULE) begin
      if (seq_spent) r.status = ST_EXHAUSTED;
      else if (c.phase == PHASE_INVALID) r.status = ST_BAD_PHASE;
      else if (pend_cnt >= DEPTH) r.status = ST_FULL;
      else begin
        pend_ev[pend_cnt] = c;
        if (!c.has_cause) pend_ev[pend_cnt].cause = '0;
        pend_seq[pend_cnt] = next_seq;
        pend_cnt++;
        r.seq_no = next_seq;
        if (next_seq == SEQ_MAX) seq_spent = 1;
        else next_seq++;
      end
    end else if (c.cmd == CMD_PEEK || c.cmd == CMD_POP) begin
      if (pend_cnt == 0) r.status = ST_EMPTY;
      else begin
        b = 0;
        for (int i = 1; i < pend_cnt; i++) begin
          if (pend_ev[i].tick != pend_ev[b].tick) begin
            if (pend_ev[i].tick < pend_ev[b].tick) b = i;
          end else if (pend_ev[i].phase != pend_ev[b].phase) begin
            if (pend_ev[i].phase < pend_ev[b].phase) b = i;
          end else if (pend_seq[i] < pend_seq[b]) b = i;
        end
        r.seq_no    = pend_seq[b];
        r.tick      = pend_ev[b].tick;
        r.phase     = pend_ev[b].phase;
        r.kind      = pend_ev[b].kind;
        r.tag       = pend_ev[b].tag;
        r.has_cause = pend_ev[b].has_cause;
        r.cause     = pend_ev[b].cause;
        if (c.cmd == CMD_POP) begin
          pend_ev[b]  = pend_ev[pend_cnt-1];
          pend_seq[b] = pend_seq[pend_cnt-1];
          pend_cnt--;
        end
      end
    end
    r.occ = pend_cnt[6:0];
    return r;
  endfunction

  // Drive one command beat and hold it until it is taken.
  task automatic send_cmd(cmd_beat_t c);
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= c.cmd;
    in_ch.event_tick    <= c.tick;
    in_ch.event_phase   <= c.phase;
    in_ch.event_kind    <= c.kind;
    in_ch.entity_tag    <= c.tag;
    in_ch.cause_present <= c.has_cause;
    in_ch.cause_number  <= c.cause;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Push the prediction before the beat leaves, so the result always finds it.
  task automatic issue(cmd_beat_t c, bit fixed, result_beat_t r);
    result_beat_t p;
    p = predict_result(c);
    expected_q.push_back(fixed ? r : p);
    send_cmd(c);
  endtask

  // Drop valid for a random gap between bursts.
  task automatic idle_gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold valid low until every result is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  function automatic cmd_beat_t rand_cmd(int sched_pct);
    cmd_beat_t c;
    c.tick = {$urandom, $urandom};
    // Crowd ticks together so phase and sequence tie-breaks get exercised.
    if ($urandom_range(0, 3) != 0) c.tick = 64'($urandom_range(0, 7));
    c.phase = ($urandom_range(0, 19) == 0) ? PHASE_INVALID : 3'($urandom_range(0, 6));
    c.kind = 8'($urandom);
    c.tag = $urandom;
    c.has_cause = 1'($urandom);
    c.cause = {$urandom, $urandom};
    if ($urandom_range(0, 99) < sched_pct) c.cmd = CMD_SCHEDULE;
    else if ($urandom_range(0, 29) == 0) c.cmd = CMD_NOP;
    else c.cmd = $urandom_range(0, 1) ? CMD_POP : CMD_PEEK;
    return c;
  endfunction

  // Receiver: stall on its own duty pattern, and check each result beat.
  initial begin
    int phase_cnt;
    result_beat_t e;
    out_ch.ready = 1'b0;
    phase_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          n_fail++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.status); n_fail++;
          end
          if (out_ch.out_sequence !== e.seq_no) begin
            $error("out_sequence exp %0h got %0h", e.seq_no, out_ch.out_sequence); n_fail++;
          end
          if (out_ch.out_tick !== e.tick) begin
            $error("out_tick exp %0h got %0h", e.tick, out_ch.out_tick); n_fail++;
          end
          if (out_ch.out_phase !== e.phase) begin
            $error("out_phase exp %0d got %0d", e.phase, out_ch.out_phase); n_fail++;
          end
          if (out_ch.out_kind !== e.kind) begin
            $error("out_kind exp %0h got %0h", e.kind, out_ch.out_kind); n_fail++;
          end
          if (out_ch.out_entity_tag !== e.tag) begin
            $error("out_entity_tag exp %0h got %0h", e.tag, out_ch.out_entity_tag); n_fail++;
          end
          if (out_ch.out_cause_present !== e.has_cause) begin
            $error("out_cause_present exp %0d got %0d", e.has_cause,
                   out_ch.out_cause_present); n_fail++;
          end
          if (out_ch.out_cause_number !== e.cause) begin
            $error("out_cause_number exp %0h got %0h", e.cause, out_ch.out_cause_number);
            n_fail++;
          end
          if (out_ch.occupancy !== e.occ) begin
            $error("occupancy exp %0d got %0d", e.occ, out_ch.occupancy); n_fail++;
          end
        end
      end
      // Long open stretches alternate with choppy stalling.
      phase_cnt = (phase_cnt + 1) % 300;
      out_ch.ready <= (phase_cnt < 100) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Sender.
  initial begin
    step_row_t dir_rows [$];
    step_row_t row;
    cmd_beat_t c;
    result_beat_t r;
    int burst, sched_pct;

    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SCHEDULE;
    in_ch.event_tick = '0;
    in_ch.event_phase = '0;
    in_ch.event_kind = '0;
    in_ch.entity_tag = '0;
    in_ch.cause_present = 1'b0;
    in_ch.cause_number = '0;
    pend_cnt = 0; next_seq = '0; seq_spent = 0; n_fail = 0;
    burst = 0; sched_pct = 50;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Fixed rows hold their own expected result.
    c = '0;
    r = '0;
    c.cmd = CMD_PEEK; r.status = ST_EMPTY;
    dir_rows.push_back('{c, 1, r});
    c.cmd = CMD_POP;
    dir_rows.push_back('{c, 1, r});
    c.cmd = CMD_NOP; r = '0;
    dir_rows.push_back('{c, 1, r});
    c = '0; c.cmd = CMD_SCHEDULE; c.phase = PHASE_INVALID; r = '0; r.status = ST_BAD_PHASE;
    dir_rows.push_back('{c, 1, r});
    // Max fields, cause given; then zero fields with a cause number but no flag.
    c = '1; c.cmd = CMD_SCHEDULE; c.phase = 3'd6; r = '0; r.occ = 7'd1;
    dir_rows.push_back('{c, 1, r});
    c = '0; c.cmd = CMD_SCHEDULE; c.cause = '1; r = '0; r.seq_no = 64'd1; r.occ = 7'd2;
    dir_rows.push_back('{c, 1, r});
    c = '0; c.cmd = CMD_PEEK;
    dir_rows.push_back('{c, 0, r});
    // Same tick: phase wins over sequence, then sequence breaks the tie.
    c = '0; c.cmd = CMD_SCHEDULE; c.tick = 64'd5; c.phase = 3'd4; c.kind = 8'h5A;
    dir_rows.push_back('{c, 0, r});
    c.phase = 3'd2; c.tag = 32'hA5A5_0001; c.has_cause = 1'b1; c.cause = 64'd3;
    dir_rows.push_back('{c, 0, r});
    c.tag = 32'hA5A5_0002;
    dir_rows.push_back('{c, 0, r});
    c = '0; c.cmd = CMD_POP;
    for (int i = 0; i < 6; i++) dir_rows.push_back('{c, 0, r});
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      issue(row.c, row.fixed, row.r);
    end

    // Fill to capacity, hit the full status, then empty it out.
    drain();
    for (int i = 0; i <= DEPTH; i++) begin
      c = rand_cmd(100);
      c.phase = 3'($urandom_range(0, 6));
      issue(c, 0, r);
    end
    for (int i = 0; i < DEPTH; i++) begin
      c = rand_cmd(0);
      c.cmd = CMD_POP;
      issue(c, 0, r);
    end

    // Random mix; the schedule share wanders so occupancy sweeps the range.
    for (int i = 0; i < 720; i++) begin
      if (i % 100 == 0) sched_pct = $urandom_range(25, 75);
      if (i == 400) drain();
      c = rand_cmd(sched_pct);
      issue(c, 0, r);
      if (burst > 0) burst--;
      else begin
        burst = $urandom_range(0, 12);
        idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
      end
    end

    // Exhaustion: the block cannot be preset, so the bench never reaches the last sequence
    // value and the predictor's seq_spent path is not exercised in normal use.
    drain();
    repeat (DEPTH + 8) @(posedge clk);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
